@@ rtl/polyline_nearest_point_projector_unit_macros.svh @@
// assertion macros for the polyline nearest point projector
`ifndef POLYLINE_NEAREST_POINT_PROJECTOR_UNIT_MACROS_SVH
`define POLYLINE_NEAREST_POINT_PROJECTOR_UNIT_MACROS_SVH

// property that holds in the same cycle
`define PNP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property whose antecedent implies the consequent in the following cycle
`define PNP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pnp_pkg.sv @@
// package with action codes, mode codes and sizes for the polyline projector
`default_nettype none
package pnp_pkg;
   localparam int unsigned ACT_W         = 2;
   localparam int unsigned COORD_W       = 32;
   localparam int unsigned MAX_POINTS_DEF = 256;

   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

   localparam logic [1:0] MODE_SEG = 2'd0;
   localparam logic [1:0] MODE_FIN = 2'd1;
   localparam logic [1:0] MODE_APP = 2'd2;

   typedef logic [ACT_W-1:0] action_type;
endpackage
`default_nettype wire

@@ rtl/polyline_nearest_point_projector_unit.sv @@
// polyline store with append, clear and nearest point query
// clear, a refused append, a spare action, a first append and a query on an empty path go
// straight to the output stage; a one-vertex query reads its vertex first; a later append runs the root unit
// a query walks every segment, through the divider unless t clamps, then computes the arc
// length; one item in flight, the next request is taken once the sequencer is back in idle
// synchronous active high reset clears the vertex count, sequencer and output valid
`default_nettype none
module polyline_nearest_point_projector_unit #(
   parameter int unsigned MAX_POINTS = pnp_pkg::MAX_POINTS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire pnp_pkg::action_type          req_action,
   input  wire logic signed [pnp_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [pnp_pkg::COORD_W-1:0] req_coord_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [7:0]                        rsp_segment_index,
   output logic signed [pnp_pkg::COORD_W-1:0] rsp_closest_x,
   output logic signed [pnp_pkg::COORD_W-1:0] rsp_closest_y,
   output logic [16:0]                       rsp_segment_fraction,
   output logic [31:0]                       rsp_arc_position,
   output logic                              rsp_path_full
);
   import pnp_pkg::*;

   localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int unsigned CW = $clog2(MAX_POINTS + 1);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_RD_A    = 5'd1;
   localparam logic [4:0] ST_RD_B    = 5'd2;
   localparam logic [4:0] ST_RD_C    = 5'd3;
   localparam logic [4:0] ST_M_AA    = 5'd4;
   localparam logic [4:0] ST_M_BB    = 5'd5;
   localparam logic [4:0] ST_AB_SUM  = 5'd6;
   localparam logic [4:0] ST_M_PA    = 5'd7;
   localparam logic [4:0] ST_M_PB    = 5'd8;
   localparam logic [4:0] ST_T_SET   = 5'd9;
   localparam logic [4:0] ST_DIV     = 5'd10;
   localparam logic [4:0] ST_M_QX    = 5'd11;
   localparam logic [4:0] ST_M_QY    = 5'd12;
   localparam logic [4:0] ST_M_EX    = 5'd13;
   localparam logic [4:0] ST_M_EY    = 5'd14;
   localparam logic [4:0] ST_CMP     = 5'd15;
   localparam logic [4:0] ST_SQRT    = 5'd16;
   localparam logic [4:0] ST_ARC_MUL = 5'd17;
   localparam logic [4:0] ST_ARC_ADD = 5'd18;
   localparam logic [4:0] ST_OUT     = 5'd19;

   // vertex memory: arc length, y and x of each vertex in one word
   logic [95:0]        vert_mem [MAX_POINTS];

   logic [4:0]         state_ff;
   logic [1:0]         mode_ff;
   logic [CW-1:0]      count_ff;
   logic [AW-1:0]      base_ff;
   logic [AW-1:0]      best_i_ff;
   logic signed [31:0] px_ff, py_ff;
   logic signed [31:0] rd_x_ff, rd_y_ff;
   logic [31:0]        rd_arc_ff;
   logic signed [31:0] ax_ff, ay_ff;
   logic signed [32:0] abx_ff, aby_ff, ex0_ff, ey0_ff;
   logic signed [67:0] prod_ff, acc_ff;
   logic [67:0]        ab2_ff;
   logic [68:0]        rem_ff;
   logic [16:0]        t_ff;
   logic [4:0]         cnt_ff;
   logic signed [33:0] qx_ff, qy_ff;
   logic [31:0]        best_qx_ff, best_qy_ff;
   logic [16:0]        best_t_ff;
   logic [67:0]        best_d2_ff;
   logic [31:0]        arc_prev_ff, len_ff;
   logic [63:0]        sq_n_ff, sq_r_ff, sq_bit_ff;
   logic [7:0]         res_idx_ff;
   logic [31:0]        res_x_ff, res_y_ff, res_arc_ff;
   logic [16:0]        res_t_ff;
   logic               res_full_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_idx_ff;
   logic [31:0]        rsp_x_ff, rsp_y_ff, rsp_arc_ff;
   logic [16:0]        rsp_t_ff;
   logic               rsp_full_ff;

   logic               req_xfer;
   logic               app_go_w, qry_go_w;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_arc;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic signed [68:0] sum_w;
   logic signed [67:0] round_w;
   logic signed [33:0] ex_w, ey_w;
   logic signed [31:0] bx_w, by_w;
   logic [68:0]        rem2_w;
   logic [63:0]        trial_w, sq_n_in, sq_r_in;
   logic [32:0]        app_tot_w;
   logic [48:0]        arc_rnd_w;
   logic [33:0]        arc_tot_w;
   logic [67:0]        d2_w;
   logic               take_w;
   logic [AW-1:0]      best_sel_w;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // request decode: appends to a non-empty, non-full path and queries on a non-empty path need the walk
   assign app_go_w = (req_action == ACT_APPEND) && (count_ff != '0)
                     && (count_ff < CW'(MAX_POINTS));
   assign qry_go_w = (req_action == ACT_QUERY) && (count_ff != '0);

   // memory read address: segment start, then its end
   assign rd_addr = (state_ff == ST_RD_B) ? AW'(base_ff + 1'b1) : base_ff;

   // memory write on append
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_arc  = '0;
      if (state_ff == ST_IDLE && req_xfer && req_action == ACT_APPEND && count_ff == '0) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_ARC_MUL && mode_ff == MODE_APP) begin
         wr_en  = 1'b1;
         wr_arc = app_tot_w[32] ? 32'hFFFF_FFFF : app_tot_w[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vert_mem[wr_addr] <= {wr_arc, (state_ff == ST_IDLE) ? {req_coord_y, req_coord_x}
                                                             : {py_ff, px_ff}};
      end
      {rd_arc_ff, rd_y_ff, rd_x_ff} <= vert_mem[rd_addr];
   end

   // shared signed multiplier operand selection
   assign ex_w = 34'(px_ff) - qx_ff;
   assign ey_w = 34'(py_ff) - qy_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M_AA: begin
            mul_a = 34'(abx_ff);
            mul_b = 34'(abx_ff);
         end
         ST_M_BB: begin
            mul_a = 34'(aby_ff);
            mul_b = 34'(aby_ff);
         end
         ST_M_PA: begin
            mul_a = 34'(ex0_ff);
            mul_b = 34'(abx_ff);
         end
         ST_M_PB: begin
            mul_a = 34'(ey0_ff);
            mul_b = 34'(aby_ff);
         end
         ST_M_QX: begin
            mul_a = 34'(abx_ff);
            mul_b = $signed({17'd0, t_ff});
         end
         ST_M_QY: begin
            mul_a = 34'(aby_ff);
            mul_b = $signed({17'd0, t_ff});
         end
         ST_M_EX: begin
            mul_a = ex_w;
            mul_b = ex_w;
         end
         ST_M_EY: begin
            mul_a = ey_w;
            mul_b = ey_w;
         end
         ST_ARC_MUL: begin
            mul_a = $signed({17'd0, best_t_ff});
            mul_b = $signed({2'd0, len_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // datapath helpers
   assign sum_w     = 69'(acc_ff) + 69'(prod_ff);
   assign round_w   = (prod_ff + 68'sd32768) >>> 16;
   assign bx_w      = (mode_ff == MODE_APP) ? px_ff : rd_x_ff;
   assign by_w      = (mode_ff == MODE_APP) ? py_ff : rd_y_ff;
   assign rem2_w    = {rem_ff[67:0], 1'b0};
   assign trial_w   = sq_r_ff + sq_bit_ff;
   assign sq_n_in   = (sq_n_ff >= trial_w) ? (sq_n_ff - trial_w) : sq_n_ff;
   assign sq_r_in   = (sq_n_ff >= trial_w) ? ((sq_r_ff >> 1) + sq_bit_ff) : (sq_r_ff >> 1);
   assign app_tot_w = 33'(arc_prev_ff) + 33'(len_ff);
   assign arc_rnd_w = prod_ff[48:0] + 49'd32768;
   assign arc_tot_w = 34'(arc_rnd_w[48:16]) + 34'(arc_prev_ff);
   assign d2_w      = sum_w[67:0];
   assign take_w    = (base_ff == '0) || (d2_w < best_d2_ff);
   assign best_sel_w = take_w ? base_ff : best_i_ff;

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_ff <= mul_p;
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  px_ff       <= req_coord_x;
                  py_ff       <= req_coord_y;
                  res_idx_ff  <= '0;
                  res_t_ff    <= '0;
                  res_arc_ff  <= '0;
                  // an empty path answers a query with the query point
                  res_x_ff    <= (req_action == ACT_QUERY && count_ff == '0) ? req_coord_x : '0;
                  res_y_ff    <= (req_action == ACT_QUERY && count_ff == '0) ? req_coord_y : '0;
                  res_full_ff <= (req_action == ACT_APPEND) && (count_ff >= CW'(MAX_POINTS));
                  base_ff     <= app_go_w ? AW'(count_ff - 1'b1) : '0;
                  mode_ff     <= app_go_w ? MODE_APP : MODE_SEG;
                  state_ff    <= (app_go_w || qry_go_w) ? ST_RD_A : ST_OUT;
                  case (req_action)
                     ACT_CLEAR: begin
                        count_ff <= '0;
                     end
                     ACT_APPEND: begin
                        if (count_ff == '0) begin
                           count_ff <= CW'(1);
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_RD_A: begin
               state_ff <= ST_RD_B;
            end
            ST_RD_B: begin
               ax_ff       <= rd_x_ff;
               ay_ff       <= rd_y_ff;
               arc_prev_ff <= rd_arc_ff;
               if (mode_ff == MODE_SEG && count_ff == CW'(1)) begin
                  res_x_ff <= rd_x_ff;
                  res_y_ff <= rd_y_ff;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_RD_C;
               end
            end
            ST_RD_C: begin
               abx_ff   <= 33'(bx_w) - 33'(ax_ff);
               aby_ff   <= 33'(by_w) - 33'(ay_ff);
               ex0_ff   <= 33'(px_ff) - 33'(ax_ff);
               ey0_ff   <= 33'(py_ff) - 33'(ay_ff);
               state_ff <= ST_M_AA;
            end
            ST_M_AA: begin
               state_ff <= ST_M_BB;
            end
            ST_M_BB: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_AB_SUM;
            end
            ST_AB_SUM: begin
               ab2_ff <= d2_w;
               if (mode_ff == MODE_SEG) begin
                  state_ff <= ST_M_PA;
               end else if (d2_w[67:64] != '0) begin
                  len_ff   <= 32'hFFFF_FFFF;
                  state_ff <= ST_ARC_MUL;
               end else begin
                  sq_n_ff   <= d2_w[63:0];
                  sq_r_ff   <= '0;
                  sq_bit_ff <= 64'h4000_0000_0000_0000;
                  cnt_ff    <= '0;
                  state_ff  <= ST_SQRT;
               end
            end
            ST_M_PA: begin
               state_ff <= ST_M_PB;
            end
            ST_M_PB: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_T_SET;
            end
            // clamp the projection fraction or start the divider
            ST_T_SET: begin
               if (ab2_ff == '0 || sum_w[68] || sum_w == '0) begin
                  t_ff     <= '0;
                  state_ff <= ST_M_QX;
               end else if ($unsigned(sum_w) >= {1'b0, ab2_ff}) begin
                  t_ff     <= 17'h10000;
                  state_ff <= ST_M_QX;
               end else begin
                  t_ff     <= '0;
                  rem_ff   <= $unsigned(sum_w);
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end
            // restoring divider, one quotient bit per cycle
            ST_DIV: begin
               if (rem2_w >= {1'b0, ab2_ff}) begin
                  rem_ff <= rem2_w - {1'b0, ab2_ff};
                  t_ff   <= {t_ff[15:0], 1'b1};
               end else begin
                  rem_ff <= rem2_w;
                  t_ff   <= {t_ff[15:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd15) begin
                  state_ff <= ST_M_QX;
               end
            end
            ST_M_QX: begin
               state_ff <= ST_M_QY;
            end
            ST_M_QY: begin
               qx_ff    <= 34'(ax_ff) + 34'(round_w);
               state_ff <= ST_M_EX;
            end
            ST_M_EX: begin
               qy_ff    <= 34'(ay_ff) + 34'(round_w);
               state_ff <= ST_M_EY;
            end
            ST_M_EY: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_CMP;
            end
            // keep the first strict minimum, then walk on or finish
            ST_CMP: begin
               if (take_w) begin
                  best_d2_ff <= d2_w;
                  best_i_ff  <= base_ff;
                  best_qx_ff <= qx_ff[31:0];
                  best_qy_ff <= qy_ff[31:0];
                  best_t_ff  <= t_ff;
               end
               if ((CW + 1)'(base_ff) + (CW + 1)'(2) < (CW + 1)'(count_ff)) begin
                  base_ff <= AW'(base_ff + 1'b1);
               end else begin
                  base_ff <= best_sel_w;
                  mode_ff <= MODE_FIN;
               end
               state_ff <= ST_RD_A;
            end
            // square root, one result bit per cycle
            ST_SQRT: begin
               sq_n_ff   <= sq_n_in;
               sq_r_ff   <= sq_r_in;
               sq_bit_ff <= sq_bit_ff >> 2;
               cnt_ff    <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd31) begin
                  len_ff   <= sq_r_in[31:0];
                  state_ff <= ST_ARC_MUL;
               end
            end
            ST_ARC_MUL: begin
               if (mode_ff == MODE_APP) begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_ARC_ADD;
               end
            end
            ST_ARC_ADD: begin
               res_idx_ff <= 8'(best_i_ff);
               res_x_ff   <= best_qx_ff;
               res_y_ff   <= best_qy_ff;
               res_t_ff   <= best_t_ff;
               res_arc_ff <= (arc_tot_w[33:32] != '0) ? 32'hFFFF_FFFF : arc_tot_w[31:0];
               state_ff   <= ST_OUT;
            end
            // hand the result to the output register
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_idx_ff   <= res_idx_ff;
                  rsp_x_ff     <= res_x_ff;
                  rsp_y_ff     <= res_y_ff;
                  rsp_t_ff     <= res_t_ff;
                  rsp_arc_ff   <= res_arc_ff;
                  rsp_full_ff  <= res_full_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_segment_index    = rsp_idx_ff;
   assign rsp_closest_x        = rsp_x_ff;
   assign rsp_closest_y        = rsp_y_ff;
   assign rsp_segment_fraction = rsp_t_ff;
   assign rsp_arc_position     = rsp_arc_ff;
   assign rsp_path_full        = rsp_full_ff;

   // checks on the sequencer and datapath
   `include "polyline_nearest_point_projector_unit_macros.svh"

   `PNP_ASSERT(a_count_bound, count_ff <= CW'(MAX_POINTS), "vertex count beyond store size")
   `PNP_ASSERT(a_div_rem, (state_ff != ST_DIV) || (rem_ff < {1'b0, ab2_ff}), "rem above divisor")
   `PNP_ASSERT_NEXT(a_clear, req_xfer && req_action == ACT_CLEAR, count_ff == '0, "clear failed")
   `PNP_ASSERT_NEXT(a_rsp_src, state_ff != ST_OUT && !rsp_valid_ff, !rsp_valid_ff, "stray result")

endmodule
`default_nettype wire
